### hw/rtl/afc_pkg.sv
// Shared constants, transfer types and helper functions of the animation frame clock.
package afc_pkg;

    // Internal precision of the frame position, the pending delta and the cycle counter.
    localparam int FRAME_BITS = 24;
    localparam int CYCLE_BITS = 16;
    localparam int PEND_BITS  = 32;

    // Fixed field widths of the channels and registers.
    localparam int FRAME_W     = 24;
    localparam int BOUND_W     = 25;
    localparam int CYCLE_OUT_W = 16;
    localparam int OP_W        = 2;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 25;

    // Working width of sums, compares and the divider dividend.
    localparam int CALC_BITS    = ((FRAME_BITS > PEND_BITS) ? FRAME_BITS : PEND_BITS) + 1;
    localparam int DIV_STEPS    = CALC_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
    localparam int REM_W        = FRAME_W + 1;
    localparam int CYC_EXT_W    = (CYCLE_BITS > CYCLE_OUT_W) ? CYCLE_BITS : CYCLE_OUT_W;

    // Item opcodes.
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE  = 2'd1;
    localparam logic [OP_W-1:0] OP_SET     = 2'd2;

    // Cycle mode codes.
    localparam logic [MODE_W-1:0] MODE_DEFAULT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CYCLIC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLAMP   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIME    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAME     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_MODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_DEFAULT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SHOWN         = 3'd6;

    // Register reset values (33.3 ms frame time, bounds unset).
    localparam logic [FRAME_W-1:0] FRAME_TIME_RST = 24'd8525;
    localparam logic [BOUND_W-1:0] BOUND_UNSET    = {BOUND_W{1'b1}};

    // Saturation limits, in the working width for the frame and the pending delta.
    localparam logic [CALC_BITS-1:0]   FRAME_MAX_C   = CALC_BITS'({FRAME_BITS{1'b1}});
    localparam logic [CALC_BITS-1:0]   PEND_MAX_C    = CALC_BITS'({PEND_BITS{1'b1}});
    localparam logic [CYCLE_BITS-1:0]  CYCLE_MAX     = {CYCLE_BITS{1'b1}};
    localparam logic [CYCLE_OUT_W-1:0] CYCLE_OUT_MAX = {CYCLE_OUT_W{1'b1}};

    // Input transfer payload.
    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [FRAME_W-1:0] elapsed;
        logic [FRAME_W-1:0] new_frame;
    } afc_in_t;

    // Output transfer payload.
    typedef struct packed {
        logic [FRAME_W-1:0]     current_frame;
        logic [CYCLE_OUT_W-1:0] cycle_total;
        logic [CYCLE_OUT_W-1:0] last_reached;
        logic                   emission_off;
    } afc_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic commit;
    } afc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
    } afc_sts_t;

    // Saturate a working-width value to the frame position width.
    function automatic logic [FRAME_BITS-1:0] sat_frame(input logic [CALC_BITS-1:0] v);
        return (v > FRAME_MAX_C) ? {FRAME_BITS{1'b1}} : v[FRAME_BITS-1:0];
    endfunction

    // Low field bits of the frame position.
    function automatic logic [FRAME_W-1:0] frame_field(input logic [FRAME_BITS-1:0] f);
        logic [CALC_BITS-1:0] e;
        e = CALC_BITS'(f);
        return e[FRAME_W-1:0];
    endfunction

    // Cycle count capped to the output field.
    function automatic logic [CYCLE_OUT_W-1:0] cycle_field(input logic [CYCLE_BITS-1:0] c);
        logic [CYC_EXT_W-1:0] e;
        e = CYC_EXT_W'(c);
        return (e > CYC_EXT_W'(CYCLE_OUT_MAX)) ? CYCLE_OUT_MAX : e[CYCLE_OUT_W-1:0];
    endfunction

endpackage

### hw/rtl/animation_frame_clock.sv
// Top level of the animation frame clock: controller plus datapath.
//
// Input channel in_valid/in_stall/in_data carries one item: advance (add
// elapsed time over frame time to the pending delta), update (apply the
// delta and validate the frame against the range) or set (load a frame).
// Every item gives exactly one result on out_valid/out_stall/out_data.
// The user must write registers through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
//
// An item is loaded, its operands are prepared, the shared restoring
// divider runs when a division is needed (33 steps, one quotient bit per
// cycle, used for the time division of an advance and for the modulo of a
// wrapping update or set), and the result is committed to the output
// register. A new item is taken once the previous one has reached the
// output register.
//
// Reset clears the frame position, pending delta and cycle count and loads
// the register defaults. When the receiver stalls, the result holds in the
// output register and one more item may be taken and worked on; it waits
// for the output register to free before its result is committed.
module animation_frame_clock (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  afc_pkg::afc_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output afc_pkg::afc_out_t               out_data,
    input  logic                            cfg_we,
    input  logic [afc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [afc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import afc_pkg::*;

    afc_cmd_t cmd;
    afc_sts_t sts;

    afc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    afc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data)
    );

endmodule

### hw/rtl/afc_div.sv
// Shared restoring divider, one quotient bit per cycle while step is high.
module afc_div (
    input  logic                           clk,
    input  logic                           start,
    input  logic                           step,
    input  logic [afc_pkg::CALC_BITS-1:0]  dividend,
    input  logic [afc_pkg::FRAME_W-1:0]    divisor,
    output logic [afc_pkg::CALC_BITS-1:0]  quotient,
    output logic [afc_pkg::FRAME_W-1:0]    remainder
);
    import afc_pkg::*;

    logic [CALC_BITS-1:0] dvd_reg, dvd_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [FRAME_W-1:0]   dsr_reg, dsr_next;
    logic [REM_W-1:0]     rem_shift;
    logic                 fits;

    // One shift-and-subtract step; quotient bits shift in behind the dividend.
    always_comb
    begin
        rem_shift = {rem_reg[FRAME_W-1:0], dvd_reg[CALC_BITS-1]};
        fits      = rem_shift >= {1'b0, dsr_reg};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (step)
        begin
            dvd_next = {dvd_reg[CALC_BITS-2:0], fits};
            rem_next = fits ? (rem_shift - {1'b0, dsr_reg}) : rem_shift;
        end
    end

    // Operand registers carry no reset.
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = dvd_reg;
    assign remainder = rem_reg[FRAME_W-1:0];

endmodule

### hw/rtl/afc_dp.sv
// Datapath: configuration, clock state, frame validation and the result register.
module afc_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [afc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [afc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  afc_pkg::afc_in_t                in_data,
    input  afc_pkg::afc_cmd_t               cmd,
    output afc_pkg::afc_sts_t               sts,
    output afc_pkg::afc_out_t               out_data
);
    import afc_pkg::*;

    // Configuration registers.
    logic [FRAME_W-1:0] frame_time_reg, frame_time_next;
    logic [FRAME_W-1:0] frame_count_reg, frame_count_next;
    logic [BOUND_W-1:0] min_frame_reg, min_frame_next;
    logic [BOUND_W-1:0] max_frame_reg, max_frame_next;
    logic [MODE_W-1:0]  cycle_mode_reg, cycle_mode_next;
    logic               cycle_default_reg, cycle_default_next;
    logic               shown_reg, shown_next;

    // Clock state.
    logic [FRAME_BITS-1:0] frame_pos_reg, frame_pos_next;
    logic [PEND_BITS-1:0]  pending_reg, pending_next;
    logic [CYCLE_BITS-1:0] cycle_cnt_reg, cycle_cnt_next;

    // Latched item and result.
    logic [OP_W-1:0]    op_reg, op_next;
    logic [FRAME_W-1:0] elapsed_reg, elapsed_next;
    logic [FRAME_W-1:0] nf_reg, nf_next;
    afc_out_t           out_reg, out_next;

    // Derived values.
    logic                  is_update, is_set, is_advance, wrap;
    logic                  min_neg, max_neg;
    logic [FRAME_W-1:0]    lo, hi, rng, ft;
    logic [CALC_BITS-1:0]  fv, lo_c, hi_c, valid_v, pend_sum;
    logic                  in_range, above;
    logic [CALC_BITS-1:0]  dividend;
    logic [FRAME_W-1:0]    divisor;
    logic [CALC_BITS-1:0]  div_quot;
    logic [FRAME_W-1:0]    div_rem;
    logic [FRAME_BITS-1:0] item_frame;
    logic [PEND_BITS-1:0]  item_pend;
    logic [CYCLE_BITS-1:0] item_cycle;
    logic                  item_emit;
    logic [CYCLE_OUT_W-1:0] item_last;

    // Configuration writes.
    always_comb
    begin
        frame_time_next    = frame_time_reg;
        frame_count_next   = frame_count_reg;
        min_frame_next     = min_frame_reg;
        max_frame_next     = max_frame_reg;
        cycle_mode_next    = cycle_mode_reg;
        cycle_default_next = cycle_default_reg;
        shown_next         = shown_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_TIME:    frame_time_next    = cfg_data[FRAME_W-1:0];
                REG_FRAME_COUNT:   frame_count_next   = cfg_data[FRAME_W-1:0];
                REG_MIN_FRAME:     min_frame_next     = cfg_data[BOUND_W-1:0];
                REG_MAX_FRAME:     max_frame_next     = cfg_data[BOUND_W-1:0];
                REG_CYCLE_MODE:    cycle_mode_next    = cfg_data[MODE_W-1:0];
                REG_CYCLE_DEFAULT: cycle_default_next = cfg_data[0];
                REG_SHOWN:         shown_next         = cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Item decode, range bounds and the frame to be validated.
    always_comb
    begin
        is_update  = (op_reg == OP_UPDATE);
        is_set     = (op_reg == OP_SET);
        is_advance = !is_update && !is_set;
        wrap       = (cycle_mode_reg == MODE_CYCLIC) ||
                     ((cycle_mode_reg != MODE_CLAMP) && cycle_default_reg);
        min_neg    = min_frame_reg[BOUND_W-1];
        max_neg    = max_frame_reg[BOUND_W-1];
        lo         = min_neg ? '0 : min_frame_reg[FRAME_W-1:0];
        hi         = max_neg ? frame_count_reg : max_frame_reg[FRAME_W-1:0];
        rng        = (hi > lo) ? (hi - lo) : (lo - hi);
        lo_c       = CALC_BITS'(lo);
        hi_c       = CALC_BITS'(hi);
        fv         = is_update ? (CALC_BITS'(frame_pos_reg) + CALC_BITS'(pending_reg))
                               : CALC_BITS'(nf_reg);
        in_range   = (fv >= lo_c) && (fv <= hi_c);
        above      = fv > hi_c;
        ft         = (frame_time_reg == '0) ? FRAME_W'(1) : frame_time_reg;
    end

    // Divider operands: time division for advance, modulo wrap otherwise.
    always_comb
    begin
        dividend     = is_advance ? CALC_BITS'({elapsed_reg, 8'h00}) : fv;
        divisor      = is_advance ? ft : rng;
        sts.need_div = is_advance ? shown_reg : (above && wrap && (rng != '0));
    end

    afc_div u_div (
        .clk       (clk),
        .start     (cmd.div_start),
        .step      (cmd.div_step),
        .dividend  (dividend),
        .divisor   (divisor),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Frame validation against the range.
    always_comb
    begin
        if (in_range)
            valid_v = fv;
        else if (above)
        begin
            if (!wrap)
                valid_v = hi_c;
            else if (rng == '0)
                valid_v = lo_c;
            else
                valid_v = CALC_BITS'(div_rem) + lo_c;
        end
        else
            valid_v = lo_c;
    end

    // Per-item results.
    always_comb
    begin
        pend_sum   = CALC_BITS'(pending_reg) + div_quot;
        item_frame = frame_pos_reg;
        item_pend  = pending_reg;
        item_cycle = cycle_cnt_reg;
        if (is_update)
        begin
            item_frame = sat_frame(valid_v);
            item_pend  = '0;
            if (wrap && (fv >= hi_c) && (cycle_cnt_reg != CYCLE_MAX))
                item_cycle = cycle_cnt_reg + CYCLE_BITS'(1);
        end
        else if (is_set)
        begin
            item_frame = sat_frame(valid_v);
            item_pend  = '0;
            item_cycle = '0;
        end
        else if (shown_reg)
            item_pend = (pend_sum > PEND_MAX_C) ? {PEND_BITS{1'b1}} : pend_sum[PEND_BITS-1:0];
        else
            item_pend = '0;

        item_emit = is_update && !max_neg && (max_frame_reg != '0) &&
                    (CALC_BITS'(item_frame) >= CALC_BITS'(max_frame_reg[FRAME_W-1:0])) &&
                    (min_frame_reg != max_frame_reg) && (cycle_mode_reg == MODE_CLAMP);

        if (!wrap)
            item_last = CYCLE_OUT_W'(CALC_BITS'(item_frame) >= hi_c);
        else if (!min_neg && (min_frame_reg == max_frame_reg))
            item_last = CYCLE_OUT_W'(1);
        else
            item_last = cycle_field(item_cycle);
    end

    // State, operand and result updates.
    always_comb
    begin
        frame_pos_next = frame_pos_reg;
        pending_next   = pending_reg;
        cycle_cnt_next = cycle_cnt_reg;
        out_next       = out_reg;
        op_next        = op_reg;
        elapsed_next   = elapsed_reg;
        nf_next        = nf_reg;
        if (cmd.load)
        begin
            op_next      = in_data.opcode;
            elapsed_next = in_data.elapsed;
            nf_next      = in_data.new_frame;
        end
        if (cmd.commit)
        begin
            frame_pos_next         = item_frame;
            pending_next           = item_pend;
            cycle_cnt_next         = item_cycle;
            out_next.current_frame = frame_field(item_frame);
            out_next.cycle_total   = cycle_field(item_cycle);
            out_next.last_reached  = item_last;
            out_next.emission_off  = item_emit;
        end
    end

    // Configuration and clock state reset to their defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_time_reg    <= FRAME_TIME_RST;
            frame_count_reg   <= '0;
            min_frame_reg     <= BOUND_UNSET;
            max_frame_reg     <= BOUND_UNSET;
            cycle_mode_reg    <= MODE_DEFAULT;
            cycle_default_reg <= 1'b0;
            shown_reg         <= 1'b1;
            frame_pos_reg     <= '0;
            pending_reg       <= '0;
            cycle_cnt_reg     <= '0;
        end
        else
        begin
            frame_time_reg    <= frame_time_next;
            frame_count_reg   <= frame_count_next;
            min_frame_reg     <= min_frame_next;
            max_frame_reg     <= max_frame_next;
            cycle_mode_reg    <= cycle_mode_next;
            cycle_default_reg <= cycle_default_next;
            shown_reg         <= shown_next;
            frame_pos_reg     <= frame_pos_next;
            pending_reg       <= pending_next;
            cycle_cnt_reg     <= cycle_cnt_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        elapsed_reg <= elapsed_next;
        nf_reg      <= nf_next;
        out_reg     <= out_next;
    end

    assign out_data = out_reg;

endmodule

### hw/rtl/afc_ctrl.sv
// Controller: item sequencing, divider step count and the output valid flag.
module afc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  afc_pkg::afc_sts_t  sts,
    output afc_pkg::afc_cmd_t  cmd
);
    import afc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PREP   = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.div_start = 1'b1;
                cnt_next      = DIV_CNT_BITS'(DIV_STEPS - 1);
                state_next    = sts.need_div ? ST_DIV : ST_FINISH;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_FINISH;
                else
                    cnt_next = cnt_reg - DIV_CNT_BITS'(1);
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // A result stays valid until its transfer completes.
    always_comb
    begin
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && out_stall))
        else $error("result committed over a stalled output");

    // An accepted item moves straight to operand preparation.
    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_PREP))
        else $error("accepted item did not start");

    // The divider runs its full step count before finishing.
    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg != '0) |=> (state_reg == ST_DIV))
        else $error("divider left early");

    // A commit always presents a valid result next cycle.
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

endmodule
